// ----- rtl/ifm_pkg.sv -----
// ----------------------------------------------------------------------------
// ifm_pkg
// Types and constants shared by the 3x3 image filter: register codes,
// filter modes, result classes and the queue entry format.
// ----------------------------------------------------------------------------
package ifm_pkg;

    localparam int PIX_W       = 8;
    localparam int ROW_W       = 16;
    localparam int OUT_COL_W   = 10;
    localparam int WIDTH_REG_W = 11;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_GREY     = 4'd3;

    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [ROW_W-1:0]       HEIGHT_RESET = 16'd1024;
    localparam logic [PIX_W-1:0]       GREY_RESET   = 8'd255;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // floor(x / 9) = (x * DIV9_MUL) >> DIV9_SHIFT for x < 32768
    localparam int SUM_W       = 12;
    localparam int DIV9_MUL_W  = 13;
    localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 13'd7282;
    localparam int DIV9_SHIFT  = 16;

    typedef enum logic [1:0] {
        MODE_SMOOTH  = 2'd0,
        MODE_INVERT  = 2'd1,
        MODE_EDGE    = 2'd2,
        MODE_SHARPEN = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CLS_ZERO,
        CLS_INVERT,
        CLS_SMOOTH,
        CLS_EDGE,
        CLS_SHARPEN
    } cls_t;

    typedef struct packed {
        mode_t                  filter_mode;
        logic [WIDTH_REG_W-1:0] image_width;
        logic [ROW_W-1:0]       image_height;
        logic [PIX_W-1:0]       max_grey;
    } cfg_t;

    typedef struct packed {
        cls_t                      cls;
        logic [8:0][PIX_W-1:0]     win;
        logic [ROW_W-1:0]          row;
        logic [OUT_COL_W-1:0]      col;
    } q_entry_t;

endpackage

// ----- rtl/ifm_ram.sv -----
// ----------------------------------------------------------------------------
// ifm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ifm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ifm_front.sv -----
// ----------------------------------------------------------------------------
// ifm_front
// Accepts pixels, keeps the raster counters, line stores and 3x3 window,
// and classifies each result before handing it to the queue.
// ----------------------------------------------------------------------------
module ifm_front import ifm_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [PIX_W-1:0]  pixel_in,
    input  logic [QCNT_W-1:0] q_count,
    output logic              push,
    output q_entry_t          push_entry
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [CW-1:0]          col_reg;
    logic [ROW_W-1:0]       row_reg;
    logic                   s1_valid_reg;
    cls_t                   s1_cls_reg;
    logic [ROW_W-1:0]       s1_row_reg;
    logic [OUT_COL_W-1:0]   s1_col_reg;
    logic [PIX_W-1:0]       s1_pix_reg;
    logic [CW-1:0]          s1_addr_reg;
    logic [8:0][PIX_W-1:0]  win_reg;
    logic [8:0][PIX_W-1:0]  win_next;

    logic                   acc;
    logic [WW-1:0]          eff_w;
    logic [ROW_W-1:0]       eff_h;
    logic                   col_last;
    logic                   row_last;
    logic                   interior;
    cls_t                   cls_next;
    logic [ROW_W-1:0]       orow_next;
    logic [OUT_COL_W-1:0]   ocol_next;
    logic [PIX_W-1:0]       mid;
    logic [PIX_W-1:0]       top;

    // room is kept for the transaction still in the read stage
    assign in_ready = ({1'b0, q_count} + {{QCNT_W{1'b0}}, s1_valid_reg})
                      < (QCNT_W+1)'(QUEUE_DEPTH);
    assign acc = in_valid && in_ready;

    always_comb
    begin
        if (cfg.image_width == '0)
        begin
            eff_w = WW'(1);
        end
        else if (32'(cfg.image_width) > MAX_WIDTH)
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(cfg.image_width);
        end
        eff_h = (cfg.image_height == '0) ? ROW_W'(1) : cfg.image_height;
    end

    assign col_last = ((WW+1)'(col_reg) + (WW+1)'(1)) >= (WW+1)'(eff_w);
    assign row_last = ((ROW_W+1)'(row_reg) + (ROW_W+1)'(1)) >= (ROW_W+1)'(eff_h);
    assign interior = (row_reg >= ROW_W'(2)) && (col_reg >= CW'(2))
                   && (((ROW_W+1)'(row_reg) + (ROW_W+1)'(1)) <= (ROW_W+1)'(eff_h))
                   && (((WW+1)'(col_reg) + (WW+1)'(1)) <= (WW+1)'(eff_w));

    // classify: the window centre trails the input by one row and one column
    always_comb
    begin
        cls_next  = CLS_ZERO;
        orow_next = '0;
        ocol_next = '0;
        if (cfg.filter_mode == MODE_INVERT)
        begin
            cls_next  = CLS_INVERT;
            orow_next = row_reg;
            ocol_next = OUT_COL_W'(col_reg);
        end
        else if ((row_reg != '0) && (col_reg != '0))
        begin
            orow_next = row_reg - ROW_W'(1);
            ocol_next = OUT_COL_W'(col_reg - CW'(1));
            if (interior)
            begin
                unique case (cfg.filter_mode)
                    MODE_SMOOTH:  cls_next = CLS_SMOOTH;
                    MODE_EDGE:    cls_next = CLS_EDGE;
                    MODE_SHARPEN: cls_next = CLS_SHARPEN;
                    default:      cls_next = CLS_INVERT;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= acc;
            if (acc)
            begin
                if (col_last)
                begin
                    col_reg <= '0;
                    row_reg <= row_last ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            if (s1_valid_reg)
            begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_cls_reg  <= cls_next;
            s1_row_reg  <= orow_next;
            s1_col_reg  <= ocol_next;
            s1_pix_reg  <= pixel_in;
            s1_addr_reg <= col_reg;
        end
    end

    // line store a: previous row, written with the new pixel
    ifm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
        .clk   (clk),
        .we    (acc),
        .waddr (col_reg),
        .wdata (pixel_in),
        .re    (acc),
        .raddr (col_reg),
        .rdata (mid)
    );

    // line store b: row before that, takes the old a word in the cycle after
    ifm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (mid),
        .re    (acc),
        .raddr (col_reg),
        .rdata (top)
    );

    always_comb
    begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = top;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = mid;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = s1_pix_reg;
    end

    assign push           = s1_valid_reg;
    assign push_entry.cls = s1_cls_reg;
    assign push_entry.win = win_next;
    assign push_entry.row = s1_row_reg;
    assign push_entry.col = s1_col_reg;

endmodule

// ----- rtl/ifm_queue.sv -----
// ----------------------------------------------------------------------------
// ifm_queue
// Short register queue between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module ifm_queue import ifm_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  q_entry_t          push_entry,
    input  logic              pop,
    output logic              q_valid,
    output q_entry_t          q_entry,
    output logic [QCNT_W-1:0] q_count
);

    q_entry_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   head_reg;
    logic [QPTR_W-1:0]   tail_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                tail_reg <= QPTR_W'((QPTR_W+1)'(tail_reg) + (QPTR_W+1)'(1));
            end
            if (pop)
            begin
                head_reg <= QPTR_W'((QPTR_W+1)'(head_reg) + (QPTR_W+1)'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_entry;
        end
    end

    assign q_valid = (count_reg != '0);
    assign q_entry = slot_reg[head_reg];
    assign q_count = count_reg;

endmodule

// ----- rtl/ifm_back.sv -----
// ----------------------------------------------------------------------------
// ifm_back
// Carries out the filter arithmetic in two stages: window sums, then the
// divide by nine and the output register.
// ----------------------------------------------------------------------------
module ifm_back import ifm_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [PIX_W-1:0]     max_grey,
    input  logic                 q_valid,
    input  q_entry_t             q_entry,
    output logic                 pop,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic [PIX_W-1:0]     pixel_out,
    output logic                 out_valid,
    output logic [ROW_W-1:0]     out_row,
    output logic [OUT_COL_W-1:0] out_col
);

    localparam int PROD_W = SUM_W + DIV9_MUL_W;

    logic                  b1_valid_reg;
    cls_t                  b1_cls_reg;
    logic [SUM_W-1:0]      b1_div_reg;
    logic [PIX_W-1:0]      b1_direct_reg;
    logic [ROW_W-1:0]      b1_row_reg;
    logic [OUT_COL_W-1:0]  b1_col_reg;

    logic                  res_valid_reg;
    logic [PIX_W-1:0]      pixel_out_reg;
    logic                  out_valid_reg;
    logic [ROW_W-1:0]      out_row_reg;
    logic [OUT_COL_W-1:0]  out_col_reg;

    logic                  out_load;
    logic                  b1_load;
    logic [SUM_W-1:0]      sum;
    logic [PIX_W-1:0]      ctr;
    logic signed [11:0]    lap;
    logic [SUM_W-1:0]      lap_abs;
    logic signed [12:0]    sharp;
    logic [PIX_W-1:0]      sharp_val;
    logic [PIX_W-1:0]      inv_val;
    logic [SUM_W-1:0]      div_next;
    logic [PIX_W-1:0]      direct_next;
    logic [PROD_W-1:0]     prod;
    logic [PIX_W-1:0]      quot;
    logic [PIX_W-1:0]      val_next;

    assign out_load = !res_valid_reg || res_ready;
    assign b1_load  = !b1_valid_reg || out_load;
    assign pop      = q_valid && b1_load;

    assign ctr = q_entry.win[4];

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < 9; k++)
        begin
            sum = sum + SUM_W'(q_entry.win[k]);
        end
    end

    // 4-neighbour laplacian and sharpen value (10*c - window sum)
    assign lap = $signed({2'b00, ctr, 2'b00})
               - $signed({4'b0000, q_entry.win[1]}) - $signed({4'b0000, q_entry.win[3]})
               - $signed({4'b0000, q_entry.win[5]}) - $signed({4'b0000, q_entry.win[7]});
    assign lap_abs = (lap < 0) ? SUM_W'(-lap) : SUM_W'(lap);
    assign sharp = $signed({2'b00, ctr, 3'b000}) + $signed({4'b0000, ctr, 1'b0})
                 - $signed({1'b0, sum});

    always_comb
    begin
        if (sharp < 0)
        begin
            sharp_val = '0;
        end
        else if (sharp > $signed({5'b00000, max_grey}))
        begin
            sharp_val = max_grey;
        end
        else
        begin
            sharp_val = PIX_W'(sharp);
        end
        inv_val = (q_entry.win[8] > max_grey) ? '0 : max_grey - q_entry.win[8];
    end

    always_comb
    begin
        div_next    = '0;
        direct_next = '0;
        unique case (q_entry.cls)
            CLS_SMOOTH:  div_next    = sum;
            CLS_EDGE:    div_next    = lap_abs;
            CLS_SHARPEN: direct_next = sharp_val;
            CLS_INVERT:  direct_next = inv_val;
            default:     direct_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (b1_load)
            begin
                b1_valid_reg <= q_valid;
            end
            if (out_load)
            begin
                res_valid_reg <= b1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b1_cls_reg    <= q_entry.cls;
            b1_div_reg    <= div_next;
            b1_direct_reg <= direct_next;
            b1_row_reg    <= q_entry.row;
            b1_col_reg    <= q_entry.col;
        end
    end

    // divide by nine as multiply by reciprocal
    assign prod = PROD_W'(b1_div_reg) * PROD_W'(DIV9_MUL);
    assign quot = prod[DIV9_SHIFT +: PIX_W];

    always_comb
    begin
        unique case (b1_cls_reg)
            CLS_SMOOTH, CLS_EDGE:     val_next = quot;
            CLS_SHARPEN, CLS_INVERT:  val_next = b1_direct_reg;
            default:                  val_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_load && b1_valid_reg)
        begin
            pixel_out_reg <= val_next;
            out_valid_reg <= (b1_cls_reg != CLS_ZERO);
            out_row_reg   <= b1_row_reg;
            out_col_reg   <= b1_col_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;

endmodule

// ----- rtl/image_3x3_filter_modes.sv -----
// ----------------------------------------------------------------------------
// image_3x3_filter_modes
// 3x3 window filter over a raster greyscale stream: smooth, invert,
// edge laplacian and sharpen, one result per pixel.
// ----------------------------------------------------------------------------
//   channel  handshake               payload
//   in       in_valid / in_ready     pixel_in
//   res      res_valid / res_ready   pixel_out, out_valid, out_row, out_col
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One pixel per clock sustained while the result channel is not stalled.
// The line stores are read at the accepting edge; the window update and
// queue write follow, then the sum stage, then the divide-by-nine multiply
// loads the output register, which drives res_valid.
// cfg_ready is always high. No clearing pass after reset: the line stores
// hold garbage until written, which only ever reaches border results.
// A four-entry queue decouples input from output; in_ready drops when it
// fills under output backpressure.
// ----------------------------------------------------------------------------
module image_3x3_filter_modes import ifm_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [PIX_W-1:0]       pixel_in,
    output logic                   res_valid,
    input  logic                   res_ready,
    output logic [PIX_W-1:0]       pixel_out,
    output logic                   out_valid,
    output logic [ROW_W-1:0]       out_row,
    output logic [OUT_COL_W-1:0]   out_col
);

    cfg_t              cfg_reg;
    cfg_t              cfg_next;
    logic              push;
    q_entry_t          push_entry;
    logic              pop;
    logic              q_valid;
    q_entry_t          q_entry;
    logic [QCNT_W-1:0] q_count;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FILTER_MODE:  cfg_next.filter_mode  = mode_t'(cfg_data[1:0]);
                REG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: cfg_next.image_height = cfg_data[ROW_W-1:0];
                REG_MAX_GREY:     cfg_next.max_grey     = cfg_data[PIX_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_mode  <= MODE_SMOOTH;
            cfg_reg.image_width  <= WIDTH_RESET;
            cfg_reg.image_height <= HEIGHT_RESET;
            cfg_reg.max_grey     <= GREY_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ifm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel_in   (pixel_in),
        .q_count    (q_count),
        .push       (push),
        .push_entry (push_entry)
    );

    ifm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .q_count    (q_count)
    );

    ifm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .max_grey  (cfg_reg.max_grey),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .pixel_out (pixel_out),
        .out_valid (out_valid),
        .out_row   (out_row),
        .out_col   (out_col)
    );

    // a transaction in the read stage always finds room in the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (q_count < QCNT_W'(QUEUE_DEPTH)) || pop)
        else $error("queue overflow on push");

    // no input taken while the queue is full
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_count == QCNT_W'(QUEUE_DEPTH)) |-> !in_ready)
        else $error("input accepted with full queue");

    // border and no-centre results carry a zero pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !out_valid) |-> (pixel_out == '0))
        else $error("flagged-invalid result with nonzero pixel");

    // an accepted pixel always reaches the queue on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> push)
        else $error("accepted pixel not pushed");

endmodule

// ----- bench/filter_window_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filter_window_checker
// Watches the config, pixel and result channels of the 3x3 image filter,
// keeps its own line stores, window and raster counters, predicts every
// result and compares it with the block's output in order.
// ----------------------------------------------------------------------------
module filter_window_checker
    import ifm_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [PIX_W-1:0]       pixel_in,
    input  logic                   res_valid,
    input  logic                   res_ready,
    input  logic [PIX_W-1:0]       pixel_out,
    input  logic                   out_valid,
    input  logic [ROW_W-1:0]       out_row,
    input  logic [OUT_COL_W-1:0]   out_col,
    output int unsigned            results_owed,
    output int unsigned            mismatches
);

    typedef struct packed {
        logic [PIX_W-1:0]     pix;
        logic                 ok;
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
    } filter_result_t;

    filter_result_t predicted_results[$];

    logic [PIX_W-1:0] prev_line  [MAX_WIDTH];
    logic [PIX_W-1:0] older_line [MAX_WIDTH];
    logic [PIX_W-1:0] win [9];
    int unsigned row_pos;
    int unsigned col_pos;
    int unsigned failures;

    mode_t                  mode_reg;
    logic [WIDTH_REG_W-1:0] width_reg;
    logic [ROW_W-1:0]       height_reg;
    logic [PIX_W-1:0]       grey_reg;

    // shifts one pixel through the line stores and window, returns its result
    function automatic filter_result_t filter_pixel(input logic [PIX_W-1:0] p);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned total;
        int lap;
        int boost;
        int k;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        filter_result_t res;
        w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h = (height_reg == 0) ? 1 : height_reg;
        r = row_pos;
        c = col_pos;
        top = older_line[c];
        mid = prev_line[c];
        older_line[c] = mid;
        prev_line[c] = p;
        for (k = 0; k < 3; k++)
        begin
            win[3*k]   = win[3*k+1];
            win[3*k+1] = win[3*k+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = p;

        res = '0;
        if (mode_reg == MODE_INVERT)
        begin
            res.pix = (p > grey_reg) ? '0 : grey_reg - p;
            res.ok  = 1'b1;
            res.row = ROW_W'(r);
            res.col = OUT_COL_W'(c);
        end
        else if (r >= 1 && c >= 1)
        begin
            // centre trails the incoming pixel by one row and one column
            res.row = ROW_W'(r - 1);
            res.col = OUT_COL_W'(c - 1);
            if (r >= 2 && c >= 2 && r <= h - 1 && c <= w - 1)
            begin
                total = 0;
                for (k = 0; k < 9; k++)
                    total += win[k];
                res.ok = 1'b1;
                case (mode_reg)
                    MODE_SMOOTH:
                        res.pix = PIX_W'(total / 9);
                    MODE_EDGE:
                    begin
                        lap = 4 * int'(win[4]) - int'(win[1]) - int'(win[3])
                            - int'(win[5]) - int'(win[7]);
                        if (lap < 0)
                            lap = -lap;
                        res.pix = PIX_W'(lap / 9);
                    end
                    default:
                    begin
                        boost = 10 * int'(win[4]) - int'(total);
                        if (boost < 0)
                            res.pix = '0;
                        else if (boost > int'(grey_reg))
                            res.pix = grey_reg;
                        else
                            res.pix = PIX_W'(boost);
                    end
                endcase
            end
        end

        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
        return res;
    endfunction

    task automatic log_failure(input string why, input filter_result_t want,
                               input filter_result_t got);
        failures++;
        if (failures <= 10)
            $display({"%0t %s: expected pixel_out %0d out_valid %0b row %0d col %0d,",
                      " got %0d %0b %0d %0d"},
                     $time, why, want.pix, want.ok, want.row, want.col,
                     got.pix, got.ok, got.row, got.col);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        filter_result_t got;
        filter_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                prev_line[i]  = '0;
                older_line[i] = '0;
            end
            for (int i = 0; i < 9; i++)
                win[i] = '0;
            row_pos    = 0;
            col_pos    = 0;
            mode_reg   = MODE_SMOOTH;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            grey_reg   = GREY_RESET;
            failures   = 0;
            predicted_results.delete();
            results_owed <= 0;
            mismatches   <= 0;
        end
        else
        begin
            // results first, so a transaction never meets its own prediction
            if (res_valid && res_ready)
            begin
                got.pix = pixel_out;
                got.ok  = out_valid;
                got.row = out_row;
                got.col = out_col;
                if (predicted_results.size() == 0)
                begin
                    log_failure("result with nothing predicted", '0, got);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (got.pix !== want.pix || got.ok !== want.ok
                        || got.row !== want.row || got.col !== want.col)
                        log_failure("result mismatch", want, got);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FILTER_MODE:  mode_reg   = mode_t'(cfg_data[1:0]);
                    REG_IMAGE_WIDTH:  width_reg  = cfg_data[WIDTH_REG_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg = cfg_data[ROW_W-1:0];
                    REG_MAX_GREY:     grey_reg   = cfg_data[PIX_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predicted_results.push_back(filter_pixel(pixel_in));
            results_owed <= predicted_results.size();
            mismatches   <= failures;
        end
    end

endmodule

// ----- bench/image_3x3_filter_modes_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_3x3_filter_modes_test
// Drives pixel images of many shapes and all four filter modes through the
// 3x3 filter with random idle and backpressure, reprograms the geometry and
// mode between images and in mid-image, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module image_3x3_filter_modes_test;
    import ifm_pkg::*;

    localparam int FRAME_MAX_WIDTH = 1024;
    localparam int RANDOM_ITEMS    = 640;
    localparam int DIRECTED_ITEMS  = 30;
    localparam int TAIL_ITEMS      = 40;
    localparam int STALL_PCT       = 36;
    // an index with no register behind it, writes must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 4'd15;

    typedef enum int { PH_IMAGES, PH_PARTIAL, PH_TALL } phase_kind_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [PIX_W-1:0]       pixel_in  = '0;
    logic                   res_valid;
    logic                   res_ready = 1'b0;
    logic [PIX_W-1:0]       pixel_out;
    logic                   out_valid;
    logic [ROW_W-1:0]       out_row;
    logic [OUT_COL_W-1:0]   out_col;
    int unsigned            results_owed;
    int unsigned            mismatches;

    int               stall_pct  = STALL_PCT;
    int unsigned      raster_col = 0;
    int unsigned      raster_row = 0;
    int unsigned      cur_width  = WIDTH_RESET;
    int unsigned      cur_height = HEIGHT_RESET;
    logic [PIX_W-1:0] cur_grey   = GREY_RESET;
    int unsigned      pixels_sent = 0;

    image_3x3_filter_modes #(
        .MAX_WIDTH (FRAME_MAX_WIDTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_in  (pixel_in),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .pixel_out (pixel_out),
        .out_valid (out_valid),
        .out_row   (out_row),
        .out_col   (out_col)
    );

    filter_window_checker #(
        .MAX_WIDTH (FRAME_MAX_WIDTH)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel_in     (pixel_in),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .pixel_out    (pixel_out),
        .out_valid    (out_valid),
        .out_row      (out_row),
        .out_col      (out_col),
        .results_owed (results_owed),
        .mismatches   (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(10_000_000);
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk)
        res_ready <= ($urandom_range(99) >= stall_pct);

    function automatic int unsigned frame_width(input logic [WIDTH_REG_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > FRAME_MAX_WIDTH)
            return FRAME_MAX_WIDTH;
        return raw;
    endfunction

    // sometimes sets the bits above the register width
    function automatic logic [CFG_DATA_W-1:0] noisy(input logic [CFG_DATA_W-1:0] value,
                                                    input int keep);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        if ($urandom_range(3) != 0)
            return value;
        return value | ((junk >> keep) << keep);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 15)
            return '0;
        if (sel < 30)
            return '1;
        if (sel < 40)
            return cur_grey;
        return PIX_W'($urandom_range(255));
    endfunction

    task automatic put_pixel(input logic [PIX_W-1:0] value);
        while ($urandom_range(99) < stall_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= value;
        do @(posedge clk); while (!in_ready);
        pixels_sent++;
        if (raster_col + 1 >= cur_width)
        begin
            raster_col = 0;
            raster_row = (raster_row + 1 >= cur_height) ? 0 : raster_row + 1;
        end
        else
        begin
            raster_col++;
        end
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] reg_index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (reg_index)
            REG_IMAGE_WIDTH:  cur_width  = frame_width(value[WIDTH_REG_W-1:0]);
            REG_IMAGE_HEIGHT: cur_height = (value == 0) ? 1 : value;
            REG_MAX_GREY:     cur_grey   = value[PIX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    task automatic finish_image();
        do put_pixel(pick_pixel()); while (raster_col != 0 || raster_row != 0);
    endtask

    // a wider line may only start on a fresh image, so close the current one
    task automatic to_origin();
        if (raster_col != 0 || raster_row != 0)
        begin
            settle();
            write_reg(REG_IMAGE_HEIGHT, 16'd1);
            cfg_valid <= 1'b0;
            finish_image();
        end
    endtask

    task automatic run_phase(input phase_kind_t kind);
        logic [CFG_DATA_W-1:0] w_data;
        logic [CFG_DATA_W-1:0] h_data;
        logic [PIX_W-1:0]      grey;
        mode_t                 mode;
        int unsigned           sel;
        settle();
        mode = mode_t'($urandom_range(3));
        sel = $urandom_range(99);
        if (kind == PH_TALL)
            w_data = CFG_DATA_W'($urandom_range(1, 4));
        else if (sel < 5)
            w_data = '0;
        else if (sel < 10)
            w_data = 16'd1;
        else
            w_data = CFG_DATA_W'($urandom_range(2, 12));
        if (kind == PH_TALL)
            h_data = ($urandom_range(1) != 0) ? 16'hFFFF : 16'($urandom_range(9, 65534));
        else
            h_data = CFG_DATA_W'($urandom_range(0, 8));
        sel = $urandom_range(99);
        grey = (sel < 10) ? 8'h00 : (sel < 20) ? 8'hFF : 8'($urandom_range(1, 254));

        if (frame_width(w_data[WIDTH_REG_W-1:0]) > cur_width
            && (raster_col != 0 || raster_row != 0))
        begin
            to_origin();
            settle();
        end
        write_reg(REG_FILTER_MODE, noisy(16'(mode), 2));
        write_reg(REG_IMAGE_WIDTH, noisy(w_data, WIDTH_REG_W));
        write_reg(REG_IMAGE_HEIGHT, h_data);
        write_reg(REG_MAX_GREY, noisy(16'(grey), PIX_W));
        if ($urandom_range(9) == 0)
            write_reg(REG_SPARE, 16'($urandom));
        cfg_valid <= 1'b0;

        case (kind)
            PH_IMAGES:  repeat ($urandom_range(1, 3)) finish_image();
            PH_PARTIAL: repeat ($urandom_range(1, 30)) put_pixel(pick_pixel());
            default:    repeat ($urandom_range(10, 40)) put_pixel(pick_pixel());
        endcase
    endtask

    initial
    begin
        int          k;
        int unsigned sel;
        int unsigned phase_num;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // 3x3 image: one interior centre
        write_reg(REG_IMAGE_WIDTH, 16'd3);
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        write_reg(REG_MAX_GREY, 16'd200);
        write_reg(REG_FILTER_MODE, 16'(MODE_SMOOTH));
        cfg_valid <= 1'b0;
        repeat (9) put_pixel(8'hFF);

        // bright centre on black clamps to max_grey
        settle();
        write_reg(REG_FILTER_MODE, 16'(MODE_SHARPEN));
        cfg_valid <= 1'b0;
        for (k = 0; k < 9; k++)
            put_pixel((k == 4) ? 8'hFF : 8'h00);

        // negative laplacian
        settle();
        write_reg(REG_FILTER_MODE, 16'(MODE_EDGE));
        cfg_valid <= 1'b0;
        for (k = 0; k < 9; k++)
            put_pixel((k == 4) ? 8'h00 : 8'hFF);

        // pixel above max_grey saturates at zero
        settle();
        write_reg(REG_FILTER_MODE, 16'(MODE_INVERT));
        cfg_valid <= 1'b0;
        put_pixel(8'hFF);
        put_pixel(8'd200);
        put_pixel(8'h00);

        phase_num = 0;
        while (pixels_sent < RANDOM_ITEMS + DIRECTED_ITEMS)
        begin
            stall_pct = (phase_num >= 4 && phase_num < 8) ? 0 : STALL_PCT;
            sel = $urandom_range(99);
            if (sel < 70)
                run_phase(PH_IMAGES);
            else if (sel < 88)
                run_phase(PH_PARTIAL);
            else
                run_phase(PH_TALL);
            phase_num++;
        end

        // width beyond the line stores and height zero, streamed with no idling
        stall_pct = 0;
        settle();
        to_origin();
        settle();
        write_reg(REG_FILTER_MODE, 16'(MODE_INVERT));
        write_reg(REG_IMAGE_WIDTH, 16'h07FF);
        write_reg(REG_IMAGE_HEIGHT, 16'h0000);
        write_reg(REG_MAX_GREY, 16'hFF);
        cfg_valid <= 1'b0;
        repeat (TAIL_ITEMS) put_pixel(pick_pixel());

        settle();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
